### src/b64e_pkg.sv
// Shared types, constants and the character map of the base64 stream encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package b64e_pkg;

    localparam int unsigned SEXTETS_PER_GROUP = 4;
    localparam logic [7:0]  CHAR_PAD          = 8'h3D;  // '='
    localparam logic [7:0]  CHAR_PLUS         = 8'h2B;  // '+'
    localparam logic [7:0]  CHAR_SLASH        = 8'h2F;  // '/'
    localparam logic [7:0]  CHAR_UPPER_A      = 8'h41;  // 'A'
    localparam logic [7:0]  LOWER_OFFSET      = 8'd71;  // 'a' - 26
    localparam logic [7:0]  DIGIT_OFFSET      = 8'd4;   // 52 - '0'
    localparam logic [5:0]  SEXTET_LOWER      = 6'd26;
    localparam logic [5:0]  SEXTET_DIGIT      = 6'd52;
    localparam logic [5:0]  SEXTET_PLUS       = 6'd62;

    // One classified group: four sextets, how many trailing '=' replace them,
    // and whether the group closes the message.
    typedef struct packed {
        logic [SEXTETS_PER_GROUP-1:0][5:0] sextet;
        logic [1:0]                        pad_cnt;
        logic                              last;
    } group_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < SEXTET_LOWER) begin
            return CHAR_UPPER_A + v8;
        end else if (v < SEXTET_DIGIT) begin
            return v8 + LOWER_OFFSET;
        end else if (v < SEXTET_PLUS) begin
            return v8 - DIGIT_OFFSET;
        end else if (v == SEXTET_PLUS) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

### src/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front end, group queue and back end.
// Depends on b64e_pkg, b64e_front, b64e_fifo and b64e_back.
//
// Encodes a stream of raw bytes into standard base64 text, one character per
// request on the master side. Each slave request carries one byte and a tlast
// flag for the final byte of a message. Every three bytes yield four characters;
// a message that ends after one or two bytes of a group is closed with "==" or
// "=" padding, and the final character of the message leaves with m_tlast high.
// The front end takes one byte per cycle as long as the group queue has room;
// the back end emits one character per cycle from the queue head through an
// output register while the queue holds a group and m_tready accepts. Sustained
// throughput is set by the back end, which spends four characters on every
// group, a message tail of one or two bytes included. When the queue is empty,
// the byte that closes a group is first written into the queue, and its first
// character is then loaded into the output register. QUEUE_DEPTH groups of slack
// decouple the two sides, so a stalled m_tready does not stop input until the queue fills.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_code
    output logic       m_tlast    // last_char
);

    logic             q_full;
    logic             q_push;
    b64e_pkg::group_t q_push_group;
    logic             q_pop;
    logic             q_head_valid;
    b64e_pkg::group_t q_head_group;

    // Classify bytes and build groups.
    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .push       (q_push),
        .push_group (q_push_group)
    );

    // Hold finished groups until the back end drains them.
    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_group (q_push_group),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_group (q_head_group)
    );

    // Emit characters one per cycle while a group is queued and the output accepts.
    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_group (q_head_group),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

### src/b64e_front.sv
// Front end of the base64 encoder: accepts bytes, tracks the group phase and
// hands finished groups to the queue. Depends on b64e_pkg.
module b64e_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                q_full,
    output logic                push,
    output b64e_pkg::group_t    push_group
);

    typedef enum logic [1:0] {
        PH_ZERO = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] pending_reg, pending_next;
    logic        accept;
    logic [23:0] triple;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign triple   = {pending_reg, in_byte};

    always_comb begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        push         = 1'b0;
        push_group   = '0;
        case (phase_reg)
            PH_ONE: begin
                if (in_last) begin
                    // two bytes then end: three characters and one pad
                    push_group.sextet[0] = triple[15:10];
                    push_group.sextet[1] = triple[9:4];
                    push_group.sextet[2] = {triple[3:0], 2'b00};
                    push_group.pad_cnt   = 2'd1;
                    push_group.last      = 1'b1;
                    push                 = accept;
                    if (accept) begin
                        phase_next   = PH_ZERO;
                        pending_next = '0;
                    end
                end else if (accept) begin
                    phase_next   = PH_TWO;
                    pending_next = triple[15:0];
                end
            end
            PH_TWO: begin
                push_group.sextet[0] = triple[23:18];
                push_group.sextet[1] = triple[17:12];
                push_group.sextet[2] = triple[11:6];
                push_group.sextet[3] = triple[5:0];
                push_group.pad_cnt   = 2'd0;
                push_group.last      = in_last;
                push                 = accept;
                if (accept) begin
                    phase_next   = PH_ZERO;
                    pending_next = '0;
                end
            end
            default: begin
                if (in_last) begin
                    // lone byte then end: two characters and two pads
                    push_group.sextet[0] = in_byte[7:2];
                    push_group.sextet[1] = {in_byte[1:0], 4'b0000};
                    push_group.pad_cnt   = 2'd2;
                    push_group.last      = 1'b1;
                    push                 = accept;
                    if (accept) begin
                        phase_next   = PH_ZERO;
                        pending_next = '0;
                    end
                end else if (accept) begin
                    phase_next   = PH_ONE;
                    pending_next = {8'h00, in_byte};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_ZERO;
            pending_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

endmodule

### src/b64e_fifo.sv
// Short group queue between the front and back ends of the base64 encoder.
// Depends on b64e_pkg for the entry type.
module b64e_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  b64e_pkg::group_t    push_group,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output b64e_pkg::group_t    head_group
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64e_pkg::group_t mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_group = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("group pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("group popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

### src/b64e_back.sv
// Back end of the base64 encoder: walks each queued group one character per
// cycle into the output register while out_ready allows. Depends on b64e_pkg.
module b64e_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  b64e_pkg::group_t    head_group,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;
    logic       is_pad;
    logic [2:0] pad_start;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign pop       = load && (idx_reg == 2'd3);
    assign pad_start = 3'd4 - {1'b0, head_group.pad_cnt};
    assign is_pad    = ({1'b0, idx_reg} >= pad_start);

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load) begin
            idx_next   = idx_reg + 1'b1;
            valid_next = 1'b1;
            char_next  = is_pad ? b64e_pkg::CHAR_PAD
                                : b64e_pkg::sextet_char(head_group.sextet[idx_reg]);
            last_next  = head_group.last && (idx_reg == 2'd3);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> $stable(idx_reg) && $stable(char_reg)
            && $stable(last_reg))
        else $error("character position moved while output stalled");

    a_last_closes_group: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && last_reg |-> idx_reg == 2'd0)
        else $error("end marker on a character that is not the fourth of a group");

    a_pad_is_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        load && idx_reg == 2'd3 && head_group.pad_cnt != 2'd0 |=>
            char_reg == b64e_pkg::CHAR_PAD)
        else $error("padded group does not end in a pad character");

endmodule
